// ----- src/bvm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvm_pkg
// Shared types and codes of the byte VM executor.
// ----------------------------------------------------------------------------
package bvm_pkg;

  typedef enum logic [2:0] {
    CMD_WR_TOKEN = 3'd0,
    CMD_WR_CELL  = 3'd1,
    CMD_EXEC     = 3'd2,
    CMD_RD_TOKEN = 3'd3,
    CMD_RD_CELL  = 3'd4,
    CMD_BEGIN    = 3'd5
  } cmd_t;

  typedef enum logic [3:0] {
    OP_MOV   = 4'd0,
    OP_ADD   = 4'd1,
    OP_SUB   = 4'd2,
    OP_MUL   = 4'd3,
    OP_DIV   = 4'd4,
    OP_XOR   = 4'd5,
    OP_OR    = 4'd6,
    OP_AND   = 4'd7,
    OP_GT    = 4'd8,
    OP_GE    = 4'd9,
    OP_EQ    = 4'd10,
    OP_NE    = 4'd11,
    OP_LE    = 4'd12,
    OP_LT    = 4'd13,
    OP_ELSE  = 4'd14,
    OP_ENDIF = 4'd15
  } op_t;

  localparam logic [1:0] MODE_DIRECT   = 2'd0;
  localparam logic [1:0] MODE_INDIRECT = 2'd1;
  localparam logic [1:0] MODE_CELL     = 2'd2;
  localparam logic [1:0] MODE_CONST    = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_W,
    ST_DPTR,
    ST_DPTR_W,
    ST_SPTR,
    ST_SPTR_W,
    ST_SRD,
    ST_SRD_W,
    ST_DRD,
    ST_DRD_W,
    ST_EXEC,
    ST_DIV,
    ST_WB,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic [3:0] opcode;
    logic [1:0] dest_mode;
    logic [1:0] src_mode;
    logic [7:0] dest_operand;
    logic [7:0] src_operand;
    logic [7:0] mem_address;
    logic [7:0] mem_data;
  } req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       write_done;
    logic [4:0] cond_level;
    logic       cond_overflow;
  } rsp_t;

  // memory access: address already reduced to the memory depth
  typedef struct packed {
    logic       rd;
    logic       we;
    logic       is_cell;
    logic [7:0] addr;
    logic [7:0] wdata;
  } mem_req_t;

  typedef struct packed {
    logic clear;
    logic push;
    logic push_bit;
    logic invert;
    logic pop;
  } cond_op_t;

endpackage

// ----- src/bvm_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvm_mem
// Token and cell memories, one access a cycle, registered read data.
// ----------------------------------------------------------------------------
module bvm_mem import bvm_pkg::*; #(
  parameter int TOKEN_MEM_DEPTH = 256,
  parameter int CELL_MEM_DEPTH  = 8
) (
  input  logic       clk,
  input  mem_req_t   req,
  output logic [7:0] rdata
);

  localparam int TAW = $clog2(TOKEN_MEM_DEPTH);
  localparam int CAW = $clog2(CELL_MEM_DEPTH);

  logic [7:0] token_mem [TOKEN_MEM_DEPTH];
  logic [7:0] cell_mem  [CELL_MEM_DEPTH];
  logic [7:0] tok_q;
  logic [7:0] cel_q;
  logic       sel_cell;

  always_ff @(posedge clk) begin
    if (req.we && !req.is_cell) begin
      token_mem[req.addr[TAW-1:0]] <= req.wdata;
    end
    if (req.we && req.is_cell) begin
      cell_mem[req.addr[CAW-1:0]] <= req.wdata;
    end
    if (req.rd) begin
      tok_q    <= token_mem[req.addr[TAW-1:0]];
      cel_q    <= cell_mem[req.addr[CAW-1:0]];
      sel_cell <= req.is_cell;
    end
  end

  assign rdata = sel_cell ? cel_q : tok_q;

endmodule

// ----- src/bvm_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvm_div
// Signed 8-bit by positive 7-bit divide, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module bvm_div (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [7:0] dividend,
  input  logic [6:0] divisor,
  output logic       done,
  output logic [7:0] quotient
);

  logic       busy;
  logic [2:0] step;
  logic [6:0] rem;
  logic [7:0] quo;
  logic [6:0] dvs;
  logic       neg;
  logic [7:0] trial;
  logic [7:0] quo_next;

  assign trial    = {rem, quo[7]};
  assign quo_next = {quo[6:0], (trial >= {1'b0, dvs})};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && !start && (step == 3'd7);
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        rem  <= '0;
        quo  <= dividend[7] ? (8'd0 - dividend) : dividend;
        dvs  <= divisor;
        neg  <= dividend[7];
      end else if (busy) begin
        rem  <= (trial >= {1'b0, dvs}) ? 7'(trial - {1'b0, dvs}) : trial[6:0];
        quo  <= quo_next;
        step <= step + 3'd1;
        if (step == 3'd7) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign quotient = neg ? (8'd0 - quo) : quo;

endmodule

// ----- src/bvm_cond.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvm_cond
// Condition bit stack with clear, push, invert-top and pop.
// ----------------------------------------------------------------------------
module bvm_cond import bvm_pkg::*; #(
  parameter int COND_DEPTH = 16,
  parameter int CW         = 5
) (
  input  logic          clk,
  input  logic          rst,
  input  cond_op_t      op,
  output logic [CW-1:0] count,
  output logic          enabled,
  output logic          full
);

  logic [COND_DEPTH-1:0] bits;
  logic [COND_DEPTH-1:0] live;

  assign full = (count == CW'(COND_DEPTH));

  always_comb begin
    for (int k = 0; k < COND_DEPTH; k++) begin
      live[k] = (CW'(k) < count);
    end
  end

  assign enabled = &(bits | ~live);

  always_ff @(posedge clk) begin
    if (rst) begin
      bits  <= '0;
      count <= '0;
    end else if (op.clear) begin
      count <= '0;
    end else if (op.push) begin
      if (!full) begin
        for (int k = 0; k < COND_DEPTH; k++) begin
          if (CW'(k) == count) begin
            bits[k] <= op.push_bit;
          end
        end
        count <= count + CW'(1);
      end
    end else if (op.invert) begin
      for (int k = 0; k < COND_DEPTH; k++) begin
        if (CW'(k + 1) == count) begin
          bits[k] <= ~bits[k];
        end
      end
    end else if (op.pop) begin
      if (count != '0) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ----- src/byte_vm_instruction_executor_core.sv -----
`timescale 1ns / 1ps
// Sequencing: loads, begin and unused commands go straight to FIN; reads pass
//   through RD_W; execute runs the chain of registered memory reads (pointer,
//   source, destination), then EXEC, the divider for a divide, and WB.
// Throughput: one item at a time; the next item is taken while a result
//   still waits in the output register.
// Reset: synchronous, clears the sequencer, the condition stack and the
//   output valid; memory contents are undefined until written.
// ----------------------------------------------------------------------------
// byte_vm_instruction_executor_core
// Sequencer around a single-port token/cell memory, a condition stack and
// an iterative divider.
// ----------------------------------------------------------------------------
module byte_vm_instruction_executor_core import bvm_pkg::*; #(
  parameter int TOKEN_MEM_DEPTH = 256,
  parameter int CELL_MEM_DEPTH  = 8,
  parameter int COND_DEPTH      = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int CW = $clog2(COND_DEPTH + 1);

  // address reduction tables, constant
  logic [7:0] tok_lut [256];
  logic [7:0] cel_lut [256];

  always_comb begin
    for (int i = 0; i < 256; i++) begin
      tok_lut[i] = 8'(i % TOKEN_MEM_DEPTH);
      cel_lut[i] = 8'(i % CELL_MEM_DEPTH);
    end
  end

  state_t     state, state_next;
  req_t       cur;
  logic [1:0] dmode;
  logic [7:0] daddr;
  logic [7:0] saddr;
  logic [7:0] s_val;
  logic [7:0] d_val;
  logic [7:0] r_val;
  logic [7:0] rd_q;
  logic       wdone_q;
  logic       ovf_q;

  mem_req_t      mreq;
  logic [7:0]    rdata;
  cond_op_t      cop;
  logic [CW-1:0] count;
  logic          enabled;
  logic          full;
  logic          div_start;
  logic          div_done;
  logic [7:0]    div_q;

  logic accept;
  logic is_arith;
  logic cmp_bit;
  logic out_free;

  assign accept    = req_valid && req_ready;
  assign req_ready = (state == ST_IDLE);
  assign out_free  = !rsp_valid || rsp_ready;
  assign is_arith  = !cur.opcode[3];

  bvm_mem #(
    .TOKEN_MEM_DEPTH(TOKEN_MEM_DEPTH),
    .CELL_MEM_DEPTH (CELL_MEM_DEPTH)
  ) u_mem (
    .clk  (clk),
    .req  (mreq),
    .rdata(rdata)
  );

  bvm_cond #(
    .COND_DEPTH(COND_DEPTH),
    .CW        (CW)
  ) u_cond (
    .clk    (clk),
    .rst    (rst),
    .op     (cop),
    .count  (count),
    .enabled(enabled),
    .full   (full)
  );

  bvm_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(d_val),
    .divisor (s_val[6:0]),
    .done    (div_done),
    .quotient(div_q)
  );

  // signed compare for the if-type opcodes
  always_comb begin
    unique case (op_t'(cur.opcode))
      OP_GT:   cmp_bit = $signed(d_val) >  $signed(s_val);
      OP_GE:   cmp_bit = $signed(d_val) >= $signed(s_val);
      OP_EQ:   cmp_bit = d_val == s_val;
      OP_NE:   cmp_bit = d_val != s_val;
      OP_LE:   cmp_bit = $signed(d_val) <= $signed(s_val);
      OP_LT:   cmp_bit = $signed(d_val) <  $signed(s_val);
      default: cmp_bit = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (req.cmd)
            CMD_RD_TOKEN, CMD_RD_CELL: state_next = ST_RD_W;
            CMD_EXEC:                  state_next = ST_DPTR;
            default:                   state_next = ST_FIN;
          endcase
        end
      end
      ST_RD_W:   state_next = ST_FIN;
      ST_DPTR:   state_next = (dmode == MODE_INDIRECT) ? ST_DPTR_W : ST_SPTR;
      ST_DPTR_W: state_next = ST_SPTR;
      ST_SPTR:   state_next = (cur.src_mode == MODE_INDIRECT) ? ST_SPTR_W : ST_SRD;
      ST_SPTR_W: state_next = ST_SRD;
      ST_SRD:    state_next = (cur.src_mode == MODE_CONST) ? ST_DRD : ST_SRD_W;
      ST_SRD_W:  state_next = ST_DRD;
      ST_DRD:    state_next = ST_DRD_W;
      ST_DRD_W:  state_next = ST_EXEC;
      ST_EXEC:   state_next = div_start ? ST_DIV : ST_WB;
      ST_DIV:    state_next = div_done ? ST_WB : ST_DIV;
      ST_WB:     state_next = ST_FIN;
      ST_FIN:    state_next = out_free ? ST_IDLE : ST_FIN;
      default:   state_next = ST_IDLE;
    endcase
  end

  // memory requests, stack operations, divider start
  always_comb begin
    mreq      = '0;
    cop       = '0;
    div_start = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (req.cmd)
            CMD_WR_TOKEN: begin
              mreq.we    = 1'b1;
              mreq.addr  = tok_lut[req.mem_address];
              mreq.wdata = req.mem_data;
            end
            CMD_WR_CELL: begin
              mreq.we      = 1'b1;
              mreq.is_cell = 1'b1;
              mreq.addr    = cel_lut[req.mem_address];
              mreq.wdata   = req.mem_data;
            end
            CMD_RD_TOKEN: begin
              mreq.rd   = 1'b1;
              mreq.addr = tok_lut[req.mem_address];
            end
            CMD_RD_CELL: begin
              mreq.rd      = 1'b1;
              mreq.is_cell = 1'b1;
              mreq.addr    = cel_lut[req.mem_address];
            end
            CMD_BEGIN: cop.clear = 1'b1;
            default: ;
          endcase
        end
      end
      ST_DPTR: begin
        mreq.rd   = (dmode == MODE_INDIRECT);
        mreq.addr = tok_lut[cur.dest_operand];
      end
      ST_SPTR: begin
        mreq.rd   = (cur.src_mode == MODE_INDIRECT);
        mreq.addr = tok_lut[cur.src_operand];
      end
      ST_SRD: begin
        mreq.rd      = (cur.src_mode != MODE_CONST);
        mreq.is_cell = (cur.src_mode == MODE_CELL);
        mreq.addr    = saddr;
      end
      ST_DRD: begin
        mreq.rd      = 1'b1;
        mreq.is_cell = (dmode == MODE_CELL);
        mreq.addr    = daddr;
      end
      ST_EXEC: begin
        div_start = (op_t'(cur.opcode) == OP_DIV) && !s_val[7] && (s_val != '0);
      end
      ST_WB: begin
        mreq.we      = is_arith && enabled;
        mreq.is_cell = (dmode == MODE_CELL);
        mreq.addr    = daddr;
        mreq.wdata   = r_val;
        cop.push     = cur.opcode[3] && (cur.opcode < OP_ELSE);
        cop.push_bit = cmp_bit;
        cop.invert   = (op_t'(cur.opcode) == OP_ELSE);
        cop.pop      = (op_t'(cur.opcode) == OP_ENDIF);
      end
      default: ;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          cur     <= req;
          dmode   <= (req.dest_mode == MODE_CONST) ? MODE_DIRECT : req.dest_mode;
          rd_q    <= '0;
          wdone_q <= 1'b0;
          ovf_q   <= 1'b0;
        end
      end
      ST_RD_W: rd_q <= rdata;
      ST_DPTR: begin
        daddr <= (dmode == MODE_CELL) ? cel_lut[cur.dest_operand]
                                      : tok_lut[cur.dest_operand];
      end
      ST_DPTR_W: daddr <= tok_lut[rdata];
      ST_SPTR: begin
        saddr <= (cur.src_mode == MODE_CELL) ? cel_lut[cur.src_operand]
                                             : tok_lut[cur.src_operand];
      end
      ST_SPTR_W: saddr <= tok_lut[rdata];
      ST_SRD:    s_val <= cur.src_operand;
      ST_SRD_W:  s_val <= rdata;
      ST_DRD_W:  d_val <= rdata;
      ST_EXEC: begin
        unique case (op_t'(cur.opcode))
          OP_MOV:  r_val <= s_val;
          OP_ADD:  r_val <= d_val + s_val;
          OP_SUB:  r_val <= d_val - s_val;
          OP_MUL:  r_val <= 8'(d_val * s_val);
          OP_XOR:  r_val <= d_val ^ s_val;
          OP_OR:   r_val <= d_val | s_val;
          OP_AND:  r_val <= d_val & s_val;
          default: r_val <= '0;   // divide by a nonpositive value gives 0
        endcase
      end
      ST_DIV: begin
        if (div_done) begin
          r_val <= div_q;
        end
      end
      ST_WB: begin
        rd_q    <= (is_arith && enabled) ? r_val : d_val;
        wdone_q <= is_arith && enabled;
        ovf_q   <= cop.push && full;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      // loading a new result wins over retiring the old one
      rsp_valid <= (state == ST_FIN && out_free) || (rsp_valid && !rsp_ready);
    end
  end

  // result register, loaded as the item retires
  always_ff @(posedge clk) begin
    if (state == ST_FIN && out_free) begin
      rsp.read_data     <= rd_q;
      rsp.write_done    <= wdone_q;
      rsp.cond_level    <= 5'(count);
      rsp.cond_overflow <= ovf_q;
    end
  end

`ifndef SYNTHESIS
  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(COND_DEPTH))
    else $error("condition level beyond depth");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != ST_IDLE)
    else $error("sequencer idle after accept");

  a_div_from_exec: assert property (@(posedge clk) disable iff (rst)
    div_start |=> state == ST_DIV)
    else $error("divider started outside execute");

  a_done_no_ovf: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp.write_done && rsp.cond_overflow))
    else $error("write and overflow in one item");
`endif

endmodule

// ----- tb/bvm_exec_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvm_exec_checker
// Watches both channels of the byte VM executor, keeps its own copy of the
// memories and condition stack, predicts each response and compares it.
// ----------------------------------------------------------------------------
module bvm_exec_checker import bvm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_ready,
  input  req_t req,
  input  logic rsp_valid,
  input  logic rsp_ready,
  input  rsp_t rsp,
  output int   errors,
  output int   pending
);

  logic [7:0] tok_mem [256];
  logic [7:0] cel_mem [8];
  logic [15:0] cstack;
  logic [4:0]  ccount;
  rsp_t        rsp_due [$];

  task automatic report(string what, int got, int want);
    $display("mismatch %0t: %s got %0h want %0h", $realtime, what, got, want);
    errors++;
  endtask

  function automatic rsp_t vm_step(req_t r);
    rsp_t o;
    logic [7:0] da, s, d, res;
    logic [1:0] dm;
    logic on, c;
    int a, b;
    o = '0;
    dm = (r.dest_mode == MODE_CONST) ? MODE_DIRECT : r.dest_mode;
    case (r.cmd)
      CMD_WR_TOKEN: tok_mem[r.mem_address] = r.mem_data;
      CMD_WR_CELL:  cel_mem[r.mem_address[2:0]] = r.mem_data;
      CMD_RD_TOKEN: o.read_data = tok_mem[r.mem_address];
      CMD_RD_CELL:  o.read_data = cel_mem[r.mem_address[2:0]];
      CMD_BEGIN:    ccount = '0;
      CMD_EXEC: begin
        da = (dm == MODE_INDIRECT) ? tok_mem[r.dest_operand] : r.dest_operand;
        d  = (dm == MODE_CELL) ? cel_mem[da[2:0]] : tok_mem[da];
        case (r.src_mode)
          MODE_DIRECT:   s = tok_mem[r.src_operand];
          MODE_INDIRECT: s = tok_mem[tok_mem[r.src_operand]];
          MODE_CELL:     s = cel_mem[r.src_operand[2:0]];
          default:       s = r.src_operand;
        endcase
        on = 1'b1;
        for (int k = 0; k < ccount; k++) if (!cstack[k]) on = 1'b0;
        a = $signed(d);
        b = $signed(s);
        if (r.opcode <= OP_AND) begin
          case (r.opcode)
            OP_MOV: res = s;
            OP_ADD: res = d + s;
            OP_SUB: res = d - s;
            OP_MUL: res = d * s;
            OP_DIV: res = (b > 0) ? 8'(a / b) : 8'd0;
            OP_XOR: res = d ^ s;
            OP_OR:  res = d | s;
            default: res = d & s;
          endcase
          if (on) begin
            if (dm == MODE_CELL) cel_mem[da[2:0]] = res;
            else tok_mem[da] = res;
            d = res;
            o.write_done = 1'b1;
          end
        end else if (r.opcode <= OP_LT) begin
          case (r.opcode)
            OP_GT: c = a > b;
            OP_GE: c = a >= b;
            OP_EQ: c = a == b;
            OP_NE: c = a != b;
            OP_LE: c = a <= b;
            default: c = a < b;
          endcase
          if (ccount < 16) begin
            cstack[ccount[3:0]] = c;
            ccount++;
          end else o.cond_overflow = 1'b1;
        end else if (r.opcode == OP_ELSE) begin
          if (ccount > 0) cstack[ccount - 1] = ~cstack[ccount - 1];
        end else if (ccount > 0) ccount--;
        o.read_data = d;
      end
      default: ;
    endcase
    o.cond_level = ccount;
    return o;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      for (int i = 0; i < 256; i++) tok_mem[i] = '0;
      for (int i = 0; i < 8; i++) cel_mem[i] = '0;
      cstack = '0;
      ccount = '0;
      rsp_due.delete();
      errors = 0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (rsp_due.size() == 0) begin
          report("unexpected response", rsp, 0);
        end else begin
          want = rsp_due.pop_front();
          if (rsp.read_data != want.read_data)
            report("read_data", rsp.read_data, want.read_data);
          if (rsp.write_done != want.write_done)
            report("write_done", rsp.write_done, want.write_done);
          if (rsp.cond_level != want.cond_level)
            report("cond_level", rsp.cond_level, want.cond_level);
          if (rsp.cond_overflow != want.cond_overflow)
            report("cond_overflow", rsp.cond_overflow, want.cond_overflow);
        end
      end
      if (req_valid && req_ready) rsp_due.push_back(vm_step(req));
    end
    pending = rsp_due.size();
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the byte VM executor: preloads both memories,
// runs directed corner items, then random condition-stack programs with
// bursty requests and a stalling response side.
// ----------------------------------------------------------------------------
module tb import bvm_pkg::*;;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;
  int   errors;
  int   pending;
  int   cycles;
  int   burst_left;

  byte_vm_instruction_executor_core dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  bvm_exec_checker chk (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // cycle count and watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 400000) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // response side: four ready patterns taken in rotation
  always @(negedge clk) begin
    case ((cycles / 97) % 4)
      0: rsp_ready <= 1'b1;
      1: rsp_ready <= 1'($urandom_range(0, 1));
      2: rsp_ready <= ($urandom_range(0, 3) == 0);
      default: rsp_ready <= ((cycles % 23) > 15);
    endcase
  end

  // random payload bits of one item
  function automatic req_t rand_bits();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[$bits(req_t)-1:0];
  endfunction

  // one item: gaps only between bursts, valid held until accepted
  task automatic send(req_t r);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(0, 6);
      repeat (gap) @(negedge clk);
    end
    burst_left--;
    req = r;
    req_valid = 1'b1;
    do @(posedge clk); while (!req_ready);
    @(negedge clk);
    req_valid = 1'b0;
    req = rand_bits();
  endtask

  function automatic req_t host(cmd_t c, logic [7:0] a, logic [7:0] v);
    req_t r;
    r = rand_bits();
    r.cmd = c;
    r.mem_address = a;
    r.mem_data = v;
    return r;
  endfunction

  function automatic req_t instr(op_t op, logic [1:0] dm, logic [1:0] sm,
                                 logic [7:0] d, logic [7:0] s);
    req_t r;
    r = rand_bits();
    r.cmd = CMD_EXEC;
    r.opcode = op;
    r.dest_mode = dm;
    r.src_mode = sm;
    r.dest_operand = d;
    r.src_operand = s;
    return r;
  endfunction

  function automatic req_t rand_item();
    req_t r;
    int p;
    r = rand_bits();
    p = $urandom_range(0, 99);
    if (p < 60) r.cmd = CMD_EXEC;
    else if (p < 68) r.cmd = CMD_WR_TOKEN;
    else if (p < 74) r.cmd = CMD_WR_CELL;
    else if (p < 84) r.cmd = CMD_RD_TOKEN;
    else if (p < 92) r.cmd = CMD_RD_CELL;
    else if (p < 95) r.cmd = CMD_BEGIN;
    else r.cmd = 3'($urandom_range(6, 7));
    // favour compares and else/endif so the stack gets deep
    if (r.cmd == CMD_EXEC && $urandom_range(0, 2) == 0)
      r.opcode = 4'($urandom_range(OP_GT, OP_ENDIF));
    return r;
  endfunction

  initial begin
    int n;
    int len;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    burst_left = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // preload every entry so no read ever hits unwritten memory
    for (int i = 0; i < 256; i++) send(host(CMD_WR_TOKEN, 8'(i), 8'($urandom)));
    for (int i = 0; i < 8; i++) send(host(CMD_WR_CELL, 8'(i), 8'($urandom)));

    // directed corners: extremes, divide cases, every op, stack edges
    send(host(CMD_WR_TOKEN, 8'd0, 8'h80));
    send(host(CMD_WR_TOKEN, 8'd255, 8'h7F));
    send(host(CMD_WR_TOKEN, 8'd1, 8'hF9));
    send(instr(OP_DIV, MODE_DIRECT, MODE_CONST, 8'd0, 8'd0));     // by zero
    send(instr(OP_DIV, MODE_DIRECT, MODE_CONST, 8'd255, 8'hFF));  // by negative
    send(instr(OP_DIV, MODE_DIRECT, MODE_CONST, 8'd1, 8'd2));     // -7/2 truncates
    send(instr(OP_DIV, MODE_DIRECT, MODE_CONST, 8'd255, 8'h7F));
    send(instr(OP_ELSE, MODE_DIRECT, MODE_CONST, 8'd0, 8'd0));    // empty stack
    send(instr(OP_ENDIF, MODE_DIRECT, MODE_CONST, 8'd0, 8'd0));
    for (int op = OP_MOV; op <= OP_ENDIF; op++)
      send(instr(op_t'(op), 2'($urandom), 2'($urandom), 8'hFF, 8'h00));
    send(instr(OP_ADD, MODE_CONST, MODE_INDIRECT, 8'h00, 8'hFF)); // mode 3 as direct
    send(host(CMD_RD_TOKEN, 8'hFF, 8'h00));
    send(host(CMD_RD_CELL, 8'hFF, 8'h00));
    send(host(cmd_t'(3'd6), 8'h00, 8'hFF));
    send(host(cmd_t'(3'd7), 8'hFF, 8'hFF));
    // overfill the stack
    for (int i = 0; i < 18; i++)
      send(instr(OP_GE, MODE_DIRECT, MODE_CONST, 8'd5, 8'($urandom)));
    send(instr(OP_ELSE, MODE_DIRECT, MODE_CONST, 8'd0, 8'd0));
    send(host(CMD_BEGIN, 8'd0, 8'd0));

    // random programs: begin and a run of random items, or a lone random item
    n = 0;
    while (n < 1036) begin
      if ($urandom_range(0, 9) != 0) begin
        send(host(CMD_BEGIN, 8'($urandom), 8'($urandom)));
        n++;
        len = $urandom_range(3, 30);
        repeat (len) begin
          send(rand_item());
          n++;
        end
      end else begin
        send(rand_bits());
        n++;
      end
    end

    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
